### rtl/core/ccgr_pkg.sv
// ---------------------------------------------------------------------------
// ccgr_pkg : shared types and tables of the character cell glyph rasterizer
// Holds the 5x7 font, the colour table, the controller state and the
// command and status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package ccgr_pkg;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 4;
    localparam int CODE_W    = 8;
    localparam int POS_W     = 12;
    localparam int RECT_W    = 13;
    localparam int DOT_W     = 8;
    localparam int COL_W     = 8;
    localparam int FONT_COLS = 5;
    localparam int FONT_ROWS = 7;
    localparam int GLYPH_W   = FONT_COLS * FONT_ROWS;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 4'd1;

    localparam logic [CFG_W-1:0] CELL_WIDTH_RST  = 10'd16;
    localparam logic [CFG_W-1:0] CELL_HEIGHT_RST = 10'd24;

    localparam logic [CODE_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CODE_W-1:0] CASE_OFFSET = 8'd32;

    // reciprocals for the constant divides, scaled by 2^10
    localparam int RECIP_SHIFT = 10;
    localparam logic [7:0] RECIP_7 = 8'd146;
    localparam logic [7:0] RECIP_9 = 8'd113;
    localparam logic [7:0] RECIP_5 = 8'd204;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MARGIN_EST,
        ST_MARGIN_FIX,
        ST_AREA,
        ST_DOT_EST,
        ST_DOT_FIX,
        ST_SPAN,
        ST_ORIGIN,
        ST_SCAN
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MARGIN_EST,
        OP_MARGIN_FIX,
        OP_AREA,
        OP_DOT_EST,
        OP_DOT_FIX,
        OP_SPAN,
        OP_ORIGIN
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
        logic   step;
        logic   emit;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic cur_bit;
        logic rest_zero;
        logic out_free;
    } dp_status_t;

    // rows top to bottom, row 0 in the top five bits, bit 4 of a row first
    function automatic logic [GLYPH_W-1:0] glyph_bits(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] up;
        logic [GLYPH_W-1:0] g;
        up = code;
        if (code >= "a" && code <= "z") begin
            up = code - CASE_OFFSET;
        end
        unique case (up)
            "#": g = {5'h0A, 5'h1F, 5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h00};
            "@": g = {5'h0E, 5'h11, 5'h17, 5'h15, 5'h17, 5'h10, 5'h0E};
            "=": g = {5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            "-": g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            ".": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
            ",": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C, 5'h08};
            ":": g = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00};
            "/": g = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
            ">": g = {5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10};
            "+": g = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
            "*": g = {5'h11, 5'h04, 5'h1F, 5'h04, 5'h11, 5'h00, 5'h00};
            "!": g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
            "0": g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            "1": g = {5'h04, 5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1F};
            "2": g = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F};
            "3": g = {5'h1F, 5'h01, 5'h02, 5'h06, 5'h01, 5'h11, 5'h0E};
            "4": g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            "5": g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
            "6": g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            "7": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            "8": g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            "9": g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
            "A": g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "B": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            "C": g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            "D": g = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
            "E": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "F": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            "G": g = {5'h0E, 5'h11, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0E};
            "H": g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "I": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
            "J": g = {5'h1F, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
            "K": g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            "L": g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            "M": g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            "N": g = {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
            "O": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "P": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            "Q": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            "R": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            "S": g = {5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E};
            "T": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "U": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "V": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            "W": g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
            "X": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            "Y": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            "Z": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            default: g = '0;
        endcase
        return g;
    endfunction

    // case-sensitive colour, {red, green, blue}
    function automatic logic [3*COL_W-1:0] glyph_colour(input logic [CODE_W-1:0] code);
        logic [3*COL_W-1:0] c;
        unique case (code)
            "@":           c = {8'd255, 8'd246, 8'd214};
            "#":           c = {8'd244, 8'd223, 8'd170};
            "H":           c = {8'd220, 8'd188, 8'd133};
            "X":           c = {8'd188, 8'd148, 8'd102};
            "=":           c = {8'd154, 8'd116, 8'd78};
            "-":           c = {8'd116, 8'd85,  8'd58};
            ":":           c = {8'd82,  8'd126, 8'd138};
            ",":           c = {8'd68,  8'd94,  8'd84};
            ".":           c = {8'd52,  8'd70,  8'd62};
            "/":           c = {8'd88,  8'd122, 8'd150};
            "E":           c = {8'd255, 8'd124, 8'd124};
            "K":           c = {8'd255, 8'd84,  8'd84};
            "C":           c = {8'd90,  8'd228, 8'd255};
            "B":           c = {8'd70,  8'd42,  8'd30};
            "*":           c = {8'd255, 8'd240, 8'd40};
            "!":           c = {8'd255, 8'd60,  8'd60};
            "+":           c = {8'd230, 8'd230, 8'd230};
            ">":           c = {8'd250, 8'd214, 8'd70};
            "W", "O":      c = {8'd255, 8'd150, 8'd120};
            "M", "u", "h": c = {8'd255, 8'd210, 8'd130};
            default:       c = {8'd214, 8'd226, 8'd224};
        endcase
        return c;
    endfunction

endpackage

### rtl/core/ccgr_ctrl.sv
// ---------------------------------------------------------------------------
// ccgr_ctrl : sequencer of the character cell glyph rasterizer
// Steps the datapath through the set-up arithmetic and the dot scan.
// ---------------------------------------------------------------------------
module ccgr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ccgr_pkg::dp_status_t  status,
    output ccgr_pkg::dp_cmd_t     cmd
);

    ccgr_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ccgr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = ccgr_pkg::OP_NONE;
        cmd.step   = 1'b0;
        cmd.emit   = 1'b0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ccgr_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ccgr_pkg::ST_MARGIN_EST;
                end
            end
            ccgr_pkg::ST_MARGIN_EST: begin
                cmd.op     = ccgr_pkg::OP_MARGIN_EST;
                state_next = ccgr_pkg::ST_MARGIN_FIX;
            end
            ccgr_pkg::ST_MARGIN_FIX: begin
                cmd.op     = ccgr_pkg::OP_MARGIN_FIX;
                state_next = ccgr_pkg::ST_AREA;
            end
            ccgr_pkg::ST_AREA: begin
                cmd.op     = ccgr_pkg::OP_AREA;
                state_next = ccgr_pkg::ST_DOT_EST;
            end
            ccgr_pkg::ST_DOT_EST: begin
                cmd.op     = ccgr_pkg::OP_DOT_EST;
                state_next = ccgr_pkg::ST_DOT_FIX;
            end
            ccgr_pkg::ST_DOT_FIX: begin
                cmd.op     = ccgr_pkg::OP_DOT_FIX;
                state_next = ccgr_pkg::ST_SPAN;
            end
            ccgr_pkg::ST_SPAN: begin
                cmd.op     = ccgr_pkg::OP_SPAN;
                state_next = ccgr_pkg::ST_ORIGIN;
            end
            ccgr_pkg::ST_ORIGIN: begin
                cmd.op = ccgr_pkg::OP_ORIGIN;
                if (status.skip) begin
                    state_next = ccgr_pkg::ST_IDLE;
                end else begin
                    state_next = ccgr_pkg::ST_SCAN;
                end
            end
            ccgr_pkg::ST_SCAN: begin
                // a clear dot moves on at once, a set dot waits for the output slot
                cmd.step = !status.cur_bit || status.out_free;
                cmd.emit = status.cur_bit && status.out_free;
                if (cmd.step && status.rest_zero) begin
                    state_next = ccgr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ccgr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/ccgr_dp.sv
// ---------------------------------------------------------------------------
// ccgr_dp : datapath of the character cell glyph rasterizer
// Cell registers, constant divides by reciprocal, dot scan and result register.
// ---------------------------------------------------------------------------
module ccgr_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [ccgr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ccgr_pkg::CFG_W-1:0]        cfg_data,
    input  logic [ccgr_pkg::CODE_W-1:0]       s_char_code,
    input  logic [ccgr_pkg::POS_W-1:0]        s_cell_x,
    input  logic [ccgr_pkg::POS_W-1:0]        s_cell_y,
    input  ccgr_pkg::dp_cmd_t                 cmd,
    output ccgr_pkg::dp_status_t              status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ccgr_pkg::RECT_W-1:0]       m_rect_x,
    output logic [ccgr_pkg::RECT_W-1:0]       m_rect_y,
    output logic [ccgr_pkg::DOT_W-1:0]        m_rect_w,
    output logic [ccgr_pkg::DOT_W-1:0]        m_rect_h,
    output logic [ccgr_pkg::COL_W-1:0]        m_red,
    output logic [ccgr_pkg::COL_W-1:0]        m_green,
    output logic [ccgr_pkg::COL_W-1:0]        m_blue,
    output logic                              m_last
);

    localparam int PROD_W = ccgr_pkg::CFG_W + 8;

    logic [ccgr_pkg::CFG_W-1:0]      cw_reg, ch_reg;
    logic [ccgr_pkg::POS_W-1:0]      cx_reg, cy_reg, cx_next, cy_next;
    logic                            space_reg, space_next;
    logic                            small_reg, small_next;
    logic [ccgr_pkg::GLYPH_W-1:0]    glyph_reg, glyph_next;
    logic [3*ccgr_pkg::COL_W-1:0]    colour_reg, colour_next;
    logic [7:0]                      mw_reg, mw_next, mh_reg, mh_next;
    logic [ccgr_pkg::CFG_W-1:0]      dw_reg, dw_next, dh_reg, dh_next;
    logic [ccgr_pkg::DOT_W-1:0]      pw_reg, pw_next, ph_reg, ph_next;
    logic [ccgr_pkg::CFG_W-1:0]      spw_reg, spw_next, sph_reg, sph_next;
    logic [ccgr_pkg::RECT_W-1:0]     ox_reg, ox_next;
    logic [ccgr_pkg::RECT_W-1:0]     xacc_reg, xacc_next, yacc_reg, yacc_next;
    logic [2:0]                      col_reg, col_next;

    logic                            mval_reg, mval_next;
    logic [ccgr_pkg::RECT_W-1:0]     mx_reg, my_reg;
    logic [ccgr_pkg::DOT_W-1:0]      mw_out_reg, mh_out_reg;
    logic [3*ccgr_pkg::COL_W-1:0]    mcol_reg;
    logic                            mlast_reg;

    logic [PROD_W-1:0]               prod_a, prod_b;
    logic [ccgr_pkg::CFG_W-1:0]      rem_a, rem_b;

    // cell registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg <= ccgr_pkg::CELL_WIDTH_RST;
            ch_reg <= ccgr_pkg::CELL_HEIGHT_RST;
        end else if (cfg_valid) begin
            if (cfg_index == ccgr_pkg::REG_CELL_WIDTH) begin
                cw_reg <= cfg_data;
            end
            if (cfg_index == ccgr_pkg::REG_CELL_HEIGHT) begin
                ch_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        space_next  = space_reg;
        small_next  = small_reg;
        glyph_next  = glyph_reg;
        colour_next = colour_reg;
        mw_next     = mw_reg;
        mh_next     = mh_reg;
        dw_next     = dw_reg;
        dh_next     = dh_reg;
        pw_next     = pw_reg;
        ph_next     = ph_reg;
        spw_next    = spw_reg;
        sph_next    = sph_reg;
        ox_next     = ox_reg;
        xacc_next   = xacc_reg;
        yacc_next   = yacc_reg;
        col_next    = col_reg;
        prod_a      = '0;
        prod_b      = '0;
        rem_a       = '0;
        rem_b       = '0;

        if (cmd.load) begin
            cx_next     = s_cell_x;
            cy_next     = s_cell_y;
            space_next  = (s_char_code == ccgr_pkg::CHAR_SPACE);
            glyph_next  = ccgr_pkg::glyph_bits(s_char_code);
            colour_next = ccgr_pkg::glyph_colour(s_char_code);
        end

        unique case (cmd.op)
            ccgr_pkg::OP_NONE: begin
            end
            ccgr_pkg::OP_MARGIN_EST: begin
                // quotient estimate, low by at most one
                prod_a  = PROD_W'(cw_reg) * PROD_W'(ccgr_pkg::RECIP_7);
                prod_b  = PROD_W'(ch_reg) * PROD_W'(ccgr_pkg::RECIP_9);
                mw_next = prod_a[ccgr_pkg::RECIP_SHIFT +: 8];
                mh_next = prod_b[ccgr_pkg::RECIP_SHIFT +: 8];
            end
            ccgr_pkg::OP_MARGIN_FIX: begin
                rem_a   = cw_reg - ccgr_pkg::CFG_W'(mw_reg) * 10'd7;
                rem_b   = ch_reg - ccgr_pkg::CFG_W'(mh_reg) * 10'd9;
                mw_next = mw_reg + 8'(rem_a >= 10'd7);
                mh_next = mh_reg + 8'(rem_b >= 10'd9);
            end
            ccgr_pkg::OP_AREA: begin
                dw_next = cw_reg - {1'b0, mw_reg, 1'b0};
                dh_next = ch_reg - {1'b0, mh_reg, 1'b0};
            end
            ccgr_pkg::OP_DOT_EST: begin
                small_next = (dw_reg < 10'd5) || (dh_reg < 10'd7);
                prod_a     = PROD_W'(dw_reg) * PROD_W'(ccgr_pkg::RECIP_5);
                prod_b     = PROD_W'(dh_reg) * PROD_W'(ccgr_pkg::RECIP_7);
                pw_next    = prod_a[ccgr_pkg::RECIP_SHIFT +: ccgr_pkg::DOT_W];
                ph_next    = prod_b[ccgr_pkg::RECIP_SHIFT +: ccgr_pkg::DOT_W];
            end
            ccgr_pkg::OP_DOT_FIX: begin
                rem_a   = dw_reg - ccgr_pkg::CFG_W'(pw_reg) * 10'd5;
                rem_b   = dh_reg - ccgr_pkg::CFG_W'(ph_reg) * 10'd7;
                pw_next = pw_reg + 8'(rem_a >= 10'd5);
                ph_next = ph_reg + 8'(rem_b >= 10'd7);
            end
            ccgr_pkg::OP_SPAN: begin
                spw_next = cw_reg - ccgr_pkg::CFG_W'(pw_reg) * 10'd5;
                sph_next = ch_reg - ccgr_pkg::CFG_W'(ph_reg) * 10'd7;
            end
            ccgr_pkg::OP_ORIGIN: begin
                ox_next   = ccgr_pkg::RECT_W'(cx_reg) + ccgr_pkg::RECT_W'(spw_reg[9:1]);
                xacc_next = ccgr_pkg::RECT_W'(cx_reg) + ccgr_pkg::RECT_W'(spw_reg[9:1]);
                yacc_next = ccgr_pkg::RECT_W'(cy_reg) + ccgr_pkg::RECT_W'(sph_reg[9:1]);
                col_next  = '0;
            end
            default: begin
            end
        endcase

        if (cmd.step) begin
            glyph_next = {glyph_reg[ccgr_pkg::GLYPH_W-2:0], 1'b0};
            if (col_reg == 3'(ccgr_pkg::FONT_COLS - 1)) begin
                col_next  = '0;
                xacc_next = ox_reg;
                yacc_next = yacc_reg + ccgr_pkg::RECT_W'(ph_reg);
            end else begin
                col_next  = col_reg + 3'd1;
                xacc_next = xacc_reg + ccgr_pkg::RECT_W'(pw_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        space_reg  <= space_next;
        small_reg  <= small_next;
        glyph_reg  <= glyph_next;
        colour_reg <= colour_next;
        mw_reg     <= mw_next;
        mh_reg     <= mh_next;
        dw_reg     <= dw_next;
        dh_reg     <= dh_next;
        pw_reg     <= pw_next;
        ph_reg     <= ph_next;
        spw_reg    <= spw_next;
        sph_reg    <= sph_next;
        ox_reg     <= ox_next;
        xacc_reg   <= xacc_next;
        yacc_reg   <= yacc_next;
        col_reg    <= col_next;
    end

    // result register
    always_comb begin
        mval_next = mval_reg;
        if (cmd.emit) begin
            mval_next = 1'b1;
        end else if (m_ready) begin
            mval_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mval_reg <= 1'b0;
        end else begin
            mval_reg <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            mx_reg     <= xacc_reg;
            my_reg     <= yacc_reg;
            mw_out_reg <= pw_reg;
            mh_out_reg <= ph_reg;
            mcol_reg   <= colour_reg;
            mlast_reg  <= status.rest_zero;
        end
    end

    assign status.skip      = space_reg || small_reg || (glyph_reg == '0);
    assign status.cur_bit   = glyph_reg[ccgr_pkg::GLYPH_W-1];
    assign status.rest_zero = (glyph_reg[ccgr_pkg::GLYPH_W-2:0] == '0);
    assign status.out_free  = !mval_reg || m_ready;

    assign m_valid  = mval_reg;
    assign m_rect_x = mx_reg;
    assign m_rect_y = my_reg;
    assign m_rect_w = mw_out_reg;
    assign m_rect_h = mh_out_reg;
    assign m_red    = mcol_reg[3*ccgr_pkg::COL_W-1 -: ccgr_pkg::COL_W];
    assign m_green  = mcol_reg[2*ccgr_pkg::COL_W-1 -: ccgr_pkg::COL_W];
    assign m_blue   = mcol_reg[ccgr_pkg::COL_W-1 -: ccgr_pkg::COL_W];
    assign m_last   = mlast_reg;

endmodule

### rtl/core/char_cell_glyph_rasterizer.sv
// ---------------------------------------------------------------------------
// char_cell_glyph_rasterizer : 5x7 font character cell rasterizer
// Turns one character into filled dot rectangles centred in its cell.
// ---------------------------------------------------------------------------
// one beat on the s_ channel carries a character code and the top left pixel
// of its cell; the block answers with one m_ beat per set dot of the 5x7
// glyph, rows top to bottom, leftmost dot first, and marks the final one with
// m_last. a space, a code with no glyph or a cell too small for a 5x7 dot
// area after margins of width/7 and height/9 gives no beats at all. glyph
// lookup ignores letter case, the colour table does not. cell width and
// height come from the cfg_ port (index 0 width, 1 height, reset 16 and 24)
// and may only be written while no character is in flight. after the
// accept cycle, set-up steps work out margins, drawable area, dot size
// and origin, each constant divide as a reciprocal multiply and a correct
// step; then the dot scan takes one glyph position per cycle up to and
// including the last set dot, a set dot waiting while the m_ side holds
// m_ready low on a full output register, and a silent item ends after the
// set-up. the next character is taken as soon as the scan ends, while its
// last beat may still sit in the output register.
module char_cell_glyph_rasterizer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ccgr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ccgr_pkg::CFG_W-1:0]        cfg_data,
    // character beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ccgr_pkg::CODE_W-1:0]       s_char_code,
    input  logic [ccgr_pkg::POS_W-1:0]        s_cell_x,
    input  logic [ccgr_pkg::POS_W-1:0]        s_cell_y,
    // rectangle beats
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ccgr_pkg::RECT_W-1:0]       m_rect_x,
    output logic [ccgr_pkg::RECT_W-1:0]       m_rect_y,
    output logic [ccgr_pkg::DOT_W-1:0]        m_rect_w,
    output logic [ccgr_pkg::DOT_W-1:0]        m_rect_h,
    output logic [ccgr_pkg::COL_W-1:0]        m_red,
    output logic [ccgr_pkg::COL_W-1:0]        m_green,
    output logic [ccgr_pkg::COL_W-1:0]        m_blue,
    output logic                              m_last
);

    ccgr_pkg::dp_cmd_t    cmd;
    ccgr_pkg::dp_status_t status;

    // cell registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: set-up steps, then one glyph position per scan cycle unless a set dot waits for the output slot
    ccgr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic, glyph shift register and output register
    ccgr_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_char_code (s_char_code),
        .s_cell_x    (s_cell_x),
        .s_cell_y    (s_cell_y),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rect_x    (m_rect_x),
        .m_rect_y    (m_rect_y),
        .m_rect_w    (m_rect_w),
        .m_rect_h    (m_rect_h),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .m_last      (m_last)
    );

`ifndef ASSERT_OFF
    // a waiting beat is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid || m_ready))
        else $error("rectangle issued over a waiting beat");

    // once the final dot goes out, the next character can be taken
    a_last_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && status.rest_zero) |=> s_ready)
        else $error("input not reopened after final rectangle");

    // dot size never drops to zero
    a_dot_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rect_w != '0) && (m_rect_h != '0))
        else $error("zero-size dot rectangle");

    // no new character while a scan is running
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !(cmd.step || cmd.emit))
        else $error("character load during scan");
`endif

endmodule

### tb/ccgr_rect_checker.sv
// ---------------------------------------------------------------------------
// ccgr_rect_checker : rectangle checker of the glyph rasterizer
// Watches the cfg_, s_ and m_ channels, keeps its own copy of the cell size,
// works out the dot rectangles of every accepted character and compares
// each m_ beat with the oldest one outstanding.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module ccgr_rect_checker
    import ccgr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [CODE_W-1:0]    s_char_code,
    input  logic [POS_W-1:0]     s_cell_x,
    input  logic [POS_W-1:0]     s_cell_y,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [RECT_W-1:0]    m_rect_x,
    input  logic [RECT_W-1:0]    m_rect_y,
    input  logic [DOT_W-1:0]     m_rect_w,
    input  logic [DOT_W-1:0]     m_rect_h,
    input  logic [COL_W-1:0]     m_red,
    input  logic [COL_W-1:0]     m_green,
    input  logic [COL_W-1:0]     m_blue,
    input  logic                 m_last,
    output int                   rect_failures,
    output int                   rects_pending
);

    localparam int MARGIN_DIV_X = 7;
    localparam int MARGIN_DIV_Y = 9;
    localparam int PRINT_CAP    = 200;

    typedef struct packed {
        logic [RECT_W-1:0] x;
        logic [RECT_W-1:0] y;
        logic [DOT_W-1:0]  w;
        logic [DOT_W-1:0]  h;
        logic [COL_W-1:0]  r;
        logic [COL_W-1:0]  g;
        logic [COL_W-1:0]  b;
        logic              last;
    } dot_rect_t;

    dot_rect_t         dot_rects_due[$];
    logic [CFG_W-1:0]  cell_w_now;
    logic [CFG_W-1:0]  cell_h_now;

    initial begin
        rect_failures = 0;
        rects_pending = 0;
    end

    // glyph rows top first, bit 4 is the leftmost dot
    function automatic logic [0:FONT_ROWS-1][FONT_COLS-1:0] font_rows(
        input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] key;
        key = (code >= "a" && code <= "z") ? code - CASE_OFFSET : code;
        case (key)
            "#": return {5'h0A, 5'h1F, 5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h00};
            "@": return {5'h0E, 5'h11, 5'h17, 5'h15, 5'h17, 5'h10, 5'h0E};
            "=": return {5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            "-": return {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            ".": return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
            ",": return {5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C, 5'h08};
            ":": return {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00};
            "/": return {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
            ">": return {5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10};
            "+": return {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
            "*": return {5'h11, 5'h04, 5'h1F, 5'h04, 5'h11, 5'h00, 5'h00};
            "!": return {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
            "0": return {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            "1": return {5'h04, 5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1F};
            "2": return {5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F};
            "3": return {5'h1F, 5'h01, 5'h02, 5'h06, 5'h01, 5'h11, 5'h0E};
            "4": return {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            "5": return {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
            "6": return {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            "7": return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            "8": return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            "9": return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
            "A": return {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "B": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            "C": return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            "D": return {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
            "E": return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "F": return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            "G": return {5'h0E, 5'h11, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0E};
            "H": return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "I": return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
            "J": return {5'h1F, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
            "K": return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            "L": return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            "M": return {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            "N": return {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
            "O": return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "P": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            "Q": return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            "R": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            "S": return {5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E};
            "T": return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "U": return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "V": return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            "W": return {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
            "X": return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            "Y": return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            "Z": return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            default: return '0;
        endcase
    endfunction

    // {red, green, blue}, exact code match
    function automatic logic [3*COL_W-1:0] char_colour(input logic [CODE_W-1:0] code);
        case (code)
            "@":           return {8'd255, 8'd246, 8'd214};
            "#":           return {8'd244, 8'd223, 8'd170};
            "H":           return {8'd220, 8'd188, 8'd133};
            "X":           return {8'd188, 8'd148, 8'd102};
            "=":           return {8'd154, 8'd116, 8'd78};
            "-":           return {8'd116, 8'd85,  8'd58};
            ":":           return {8'd82,  8'd126, 8'd138};
            ",":           return {8'd68,  8'd94,  8'd84};
            ".":           return {8'd52,  8'd70,  8'd62};
            "/":           return {8'd88,  8'd122, 8'd150};
            "E":           return {8'd255, 8'd124, 8'd124};
            "K":           return {8'd255, 8'd84,  8'd84};
            "C":           return {8'd90,  8'd228, 8'd255};
            "B":           return {8'd70,  8'd42,  8'd30};
            "*":           return {8'd255, 8'd240, 8'd40};
            "!":           return {8'd255, 8'd60,  8'd60};
            "+":           return {8'd230, 8'd230, 8'd230};
            ">":           return {8'd250, 8'd214, 8'd70};
            "W", "O":      return {8'd255, 8'd150, 8'd120};
            "M", "u", "h": return {8'd255, 8'd210, 8'd130};
            default:       return {8'd214, 8'd226, 8'd224};
        endcase
    endfunction

    // queue the dot rectangles of one character cell
    function automatic void predict_dots(input logic [CODE_W-1:0] code,
                                         input logic [POS_W-1:0] cx,
                                         input logic [POS_W-1:0] cy);
        int unsigned cw, ch, dw, dh, pw, ph, ox, oy, total, n;
        logic [0:FONT_ROWS-1][FONT_COLS-1:0] rows;
        logic [3*COL_W-1:0] rgb;
        dot_rect_t d;
        if (code == CHAR_SPACE) return;
        cw = cell_w_now;
        ch = cell_h_now;
        dw = cw - 2 * (cw / MARGIN_DIV_X);
        dh = ch - 2 * (ch / MARGIN_DIV_Y);
        if (dw < FONT_COLS || dh < FONT_ROWS) return;
        pw = dw / FONT_COLS;
        ph = dh / FONT_ROWS;
        ox = cx + (cw - pw * FONT_COLS) / 2;
        oy = cy + (ch - ph * FONT_ROWS) / 2;
        rows  = font_rows(code);
        rgb   = char_colour(code);
        total = $countones(rows);
        n     = 0;
        for (int row = 0; row < FONT_ROWS; row++) begin
            for (int col = 0; col < FONT_COLS; col++) begin
                if (rows[row][FONT_COLS-1-col]) begin
                    n++;
                    d.x    = RECT_W'(ox + col * pw);
                    d.y    = RECT_W'(oy + row * ph);
                    d.w    = DOT_W'(pw);
                    d.h    = DOT_W'(ph);
                    d.r    = rgb[3*COL_W-1:2*COL_W];
                    d.g    = rgb[2*COL_W-1:COL_W];
                    d.b    = rgb[COL_W-1:0];
                    d.last = (n == total);
                    dot_rects_due.push_back(d);
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        rect_failures++;
        if (rect_failures <= PRINT_CAP)
            $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
    endtask

    always @(posedge aclk) begin
        dot_rect_t seen;
        dot_rect_t want;
        if (!aresetn) begin
            cell_w_now = CELL_WIDTH_RST;
            cell_h_now = CELL_HEIGHT_RST;
            dot_rects_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_CELL_WIDTH)
                    cell_w_now = cfg_data;
                else if (cfg_index == REG_CELL_HEIGHT)
                    cell_h_now = cfg_data;
            end
            if (s_valid && s_ready)
                predict_dots(s_char_code, s_cell_x, s_cell_y);
            if (m_valid && m_ready) begin
                seen = {m_rect_x, m_rect_y, m_rect_w, m_rect_h,
                        m_red, m_green, m_blue, m_last};
                if (dot_rects_due.size() == 0) begin
                    report_mismatch("rect beat with none due, rect_x", 0, seen.x);
                end else begin
                    want = dot_rects_due.pop_front();
                    if (seen.x !== want.x)       report_mismatch("rect_x", want.x, seen.x);
                    if (seen.y !== want.y)       report_mismatch("rect_y", want.y, seen.y);
                    if (seen.w !== want.w)       report_mismatch("rect_w", want.w, seen.w);
                    if (seen.h !== want.h)       report_mismatch("rect_h", want.h, seen.h);
                    if (seen.r !== want.r)       report_mismatch("red", want.r, seen.r);
                    if (seen.g !== want.g)       report_mismatch("green", want.g, seen.g);
                    if (seen.b !== want.b)       report_mismatch("blue", want.b, seen.b);
                    if (seen.last !== want.last) report_mismatch("last", want.last, seen.last);
                end
            end
        end
        rects_pending <= dot_rects_due.size();
    end

endmodule

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench : top level test of the character cell glyph rasterizer
// Drives characters and cell sizes into the block, with random idle bursts
// on both channels, and leaves prediction and checking of every dot
// rectangle beat to the checker beside it.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import ccgr_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 10;
    // long enough for the set-up of a silent item to finish
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 28;
    localparam int RUN_LIMIT_NS  = 4_000_000;
    localparam int POS_MAX       = 4095;

    // index values the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

    // codes that hit the font, upper and lower case
    localparam string GLYPH_CODES =
        "#@=-.,:/>+*!0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyzhuHUMWO";

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [CODE_W-1:0]    s_char_code = '0;
    logic [POS_W-1:0]     s_cell_x    = '0;
    logic [POS_W-1:0]     s_cell_y    = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [RECT_W-1:0]    m_rect_x;
    logic [RECT_W-1:0]    m_rect_y;
    logic [DOT_W-1:0]     m_rect_w;
    logic [DOT_W-1:0]     m_rect_h;
    logic [COL_W-1:0]     m_red;
    logic [COL_W-1:0]     m_green;
    logic [COL_W-1:0]     m_blue;
    logic                 m_last;

    int rect_failures;
    int rects_pending;

    // percentage that steers idle bursts on both sides, 0 means none
    int idle_odds = 25;
    int rx_hold   = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    char_cell_glyph_rasterizer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_cell_x    (s_cell_x),
        .s_cell_y    (s_cell_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rect_x    (m_rect_x),
        .m_rect_y    (m_rect_y),
        .m_rect_w    (m_rect_w),
        .m_rect_h    (m_rect_h),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .m_last      (m_last)
    );

    ccgr_rect_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_cell_x      (s_cell_x),
        .s_cell_y      (s_cell_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rect_x      (m_rect_x),
        .m_rect_y      (m_rect_y),
        .m_rect_w      (m_rect_w),
        .m_rect_h      (m_rect_h),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_last        (m_last),
        .rect_failures (rect_failures),
        .rects_pending (rects_pending)
    );

    // rectangle sink: m_ready drops for bursts of random length
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (aresetn && idle_odds > 0 && $urandom_range(0, 99) < idle_odds / 3) begin
            m_ready <= 1'b0;
            rx_hold <= $urandom_range(0, 10);
        end else begin
            m_ready <= aresetn;
        end
    end

    // one character beat, maybe after an idle burst; valid stays high on
    // return so back-to-back beats never drop it
    task automatic send_char(input logic [CODE_W-1:0] code,
                             input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= code;
        s_cell_x    <= x;
        s_cell_y    <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // drop valid and wait until every rectangle beat is out and the scan
    // of any silent character has had time to finish
    task automatic drain_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (rects_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // new cell size, with a write to an unused index in between
    task automatic set_cell(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic [CFG_IDX_W-1:0] spare);
        drain_block();
        write_reg(REG_CELL_WIDTH, w);
        write_reg(spare, CFG_W'($urandom));
        write_reg(REG_CELL_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CODE_W-1:0] pick_code();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return GLYPH_CODES[$urandom_range(0, GLYPH_CODES.len() - 1)];
        else if (sel < 78)
            return CHAR_SPACE;
        else
            return CODE_W'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] pick_size(input int lo, input int hi);
        case ($urandom_range(0, 7))
            0:       return CFG_W'($urandom_range(0, 9));
            1:       return '1;
            2:       return CFG_W'($urandom_range(10, 1023));
            default: return CFG_W'($urandom_range(lo, hi));
        endcase
    endfunction

    initial begin
        #RUN_LIMIT_NS;
        $display("testbench failed");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at the reset cell size of 16 by 24
        send_char(CHAR_SPACE, 12'd100, 12'd100);      // space is silent
        send_char(8'h00, 12'd0, 12'd0);               // no glyph
        send_char(8'hFF, POS_MAX, POS_MAX);           // top code, no glyph
        send_char(8'h80, 12'd12, 12'd34);
        send_char("~", 12'd7, 12'd9);
        send_char("A", 12'd0, 12'd0);
        send_char("a", POS_MAX, 12'd0);               // case folded glyph
        send_char("z", 12'd0, POS_MAX);
        send_char("H", 12'd40, 12'd40);
        send_char("h", 12'd40, 12'd40);               // lower case keeps its own colour
        send_char("U", 12'd56, 12'd0);
        send_char("u", 12'd56, 12'd0);
        send_char("M", 12'd1, 12'd2);
        send_char("W", 12'd3, 12'd4);
        send_char("O", 12'd5, 12'd6);
        send_char("@", POS_MAX, POS_MAX);             // most dots of the font, tied with B
        send_char("#", 12'd2048, 12'd1024);
        send_char("8", 12'd1365, 12'd2730);
        send_char(".", 12'd10, 12'd10);
        send_char("D", 12'd20, 12'd20);               // default colour

        // size edges: zero, just too small each way, smallest area, largest
        set_cell(10'd0, 10'd0, REG_SPARE_HI);
        send_char("@", 12'd8, 12'd8);
        set_cell(10'd4, 10'd24, REG_SPARE_LO);
        send_char("A", 12'd8, 12'd8);
        set_cell(10'd16, 10'd6, REG_SPARE_HI);
        send_char("A", 12'd8, 12'd8);
        set_cell(10'd5, 10'd7, REG_SPARE_LO);
        send_char("#", POS_MAX, POS_MAX);
        set_cell(10'd1023, 10'd1023, REG_SPARE_HI);
        send_char("@", POS_MAX, POS_MAX);

        // random phases, each with its own cell size and idle pressure;
        // the last phase runs flat out
        for (int phase = 0; phase < PHASES; phase++) begin
            set_cell(pick_size(5, 80), pick_size(7, 100),
                     CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)));
            if (phase == PHASES - 1) begin
                idle_odds = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0:       idle_odds = 0;
                    1:       idle_odds = 10;
                    2:       idle_odds = 30;
                    default: idle_odds = 60;
                endcase
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_char(pick_code(), POS_W'($urandom_range(0, POS_MAX)),
                          POS_W'($urandom_range(0, POS_MAX)));
        end

        drain_block();
        if (rect_failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

### files.f
rtl/core/ccgr_pkg.sv
rtl/core/ccgr_ctrl.sv
rtl/core/ccgr_dp.sv
rtl/core/char_cell_glyph_rasterizer.sv
tb/ccgr_rect_checker.sv
tb/testbench.sv
